// File: src/hfpf_pkg.sv
// Shared types and constants for the header/footer packet framer.
`default_nettype none

package hfpf_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SKIP_BYTES = 4;

    localparam logic [15:0] RST_BLOCK_LENGTH  = 16'd512;
    localparam logic [7:0]  RST_HEADER_FIRST  = 8'd170;
    localparam logic [7:0]  RST_HEADER_SECOND = 8'd85;
    localparam logic [7:0]  RST_FOOTER_FIRST  = 8'd85;
    localparam logic [7:0]  RST_FOOTER_SECOND = 8'd170;
    localparam logic [15:0] RST_LENGTH_LIMIT  = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LENGTH    = 3'd0,
        CFG_HEADER_FIRST    = 3'd1,
        CFG_HEADER_SECOND   = 3'd2,
        CFG_FOOTER_FIRST    = 3'd3,
        CFG_FOOTER_SECOND   = 3'd4,
        CFG_MAX_LENGTH      = 3'd5,
        CFG_EXPECTED_LENGTH = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] block_length;
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  footer_first;
        logic [7:0]  footer_second;
        logic [15:0] max_length;
        logic [15:0] expected_length;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/hfpf_cfg.sv
// Configuration register file for the header/footer packet framer.
`default_nettype none

module hfpf_cfg #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hfpf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hfpf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output hfpf_pkg::t_cfg                        o_cfg
);

    localparam logic [15:0] LEN_MASK = (LENGTH_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << LENGTH_BITS) - 32'd1);

    hfpf_pkg::t_cfg r_cfg;
    hfpf_pkg::t_cfg n_cfg;
    logic [15:0]    w_len;
    logic [7:0]     w_byte;

    assign w_len  = i_cfg_data[15:0] & LEN_MASK;
    assign w_byte = i_cfg_data[7:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (hfpf_pkg::t_cfg_idx'(i_cfg_idx))
                hfpf_pkg::CFG_BLOCK_LENGTH:    n_cfg.block_length    = w_len;
                hfpf_pkg::CFG_HEADER_FIRST:    n_cfg.header_first    = w_byte;
                hfpf_pkg::CFG_HEADER_SECOND:   n_cfg.header_second   = w_byte;
                hfpf_pkg::CFG_FOOTER_FIRST:    n_cfg.footer_first    = w_byte;
                hfpf_pkg::CFG_FOOTER_SECOND:   n_cfg.footer_second   = w_byte;
                hfpf_pkg::CFG_MAX_LENGTH:      n_cfg.max_length      = w_len;
                hfpf_pkg::CFG_EXPECTED_LENGTH: n_cfg.expected_length = w_len;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_length    <= hfpf_pkg::RST_BLOCK_LENGTH;
            r_cfg.header_first    <= hfpf_pkg::RST_HEADER_FIRST;
            r_cfg.header_second   <= hfpf_pkg::RST_HEADER_SECOND;
            r_cfg.footer_first    <= hfpf_pkg::RST_FOOTER_FIRST;
            r_cfg.footer_second   <= hfpf_pkg::RST_FOOTER_SECOND;
            r_cfg.max_length      <= hfpf_pkg::RST_LENGTH_LIMIT & LEN_MASK;
            r_cfg.expected_length <= hfpf_pkg::RST_LENGTH_LIMIT & LEN_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/header_footer_packet_framer.sv
// Top level of the header/footer packet framer: input stage, framing logic, result stage.
`default_nettype none

// Channel   Handshake           Payload
// input     i_valid / o_stall   i_data_byte
// output    o_valid / i_stall   o_store_count .. o_byte_total
// config    i_cfg_we            i_cfg_idx, i_cfg_data
//
// One byte per cycle unless the result stalls; bytes pass the input, then result register.
// Framing for a byte is done in one pass from the input register into the result register.
// Reset clears valid flags, framing state and counters and restores register defaults.
// A stalled result holds; the input stage keeps one transaction and stalls only when full.

module header_footer_packet_framer #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output      logic                             o_stall,
    input  wire logic [7:0]                       i_data_byte,
    output      logic                             o_valid,
    input  wire logic                             i_stall,
    output      logic [1:0]                       o_store_count,
    output      logic [7:0]                       o_first_byte,
    output      logic [7:0]                       o_second_byte,
    output      logic                             o_buffer_index,
    output      logic [15:0]                      o_packet_length,
    output      logic                             o_packet_end,
    output      logic                             o_packet_complete,
    output      logic [31:0]                      o_header_total,
    output      logic [31:0]                      o_footer_total,
    output      logic [31:0]                      o_complete_total,
    output      logic [63:0]                      o_byte_total,
    input  wire logic                             i_cfg_we,
    input  wire logic [hfpf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hfpf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = (LENGTH_BITS + 1 > 16) ? LENGTH_BITS + 1 : 16;

    hfpf_pkg::t_cfg cfg;

    hfpf_cfg #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input stage
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       adv;

    assign adv     = r_in_vld && (!o_valid || !i_stall);
    assign o_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    // framing state
    logic [7:0]             r_prev;
    logic                   r_prev_vld;
    logic [LENGTH_BITS-1:0] r_offset;
    logic                   r_capt;
    logic [LENGTH_BITS-1:0] r_stored;
    logic                   r_buf;
    logic [31:0]            r_hdr_cnt;
    logic [31:0]            r_ftr_cnt;
    logic [31:0]            r_cmp_cnt;
    logic [63:0]            r_byte_cnt;

    logic [LENGTH_BITS-1:0] n_offset;
    logic                   n_capt;
    logic [LENGTH_BITS-1:0] n_stored;
    logic                   n_buf;
    logic [31:0]            n_hdr_cnt;
    logic [31:0]            n_ftr_cnt;
    logic [31:0]            n_cmp_cnt;
    logic [1:0]             n_count;
    logic [7:0]             n_first;
    logic [7:0]             n_second;
    logic                   n_end;
    logic                   n_cmp;

    logic                   framing;
    logic                   hdr_hit;
    logic                   ftr_hit;
    logic [LENGTH_BITS-1:0] stored_inc;

    assign framing    = CW'(r_offset) >= CW'(hfpf_pkg::SKIP_BYTES);
    assign hdr_hit    = r_prev_vld && (r_prev == cfg.header_first)
                        && (r_in_byte == cfg.header_second);
    assign ftr_hit    = r_prev_vld && (r_prev == cfg.footer_first)
                        && (r_in_byte == cfg.footer_second);
    assign stored_inc = r_stored + 1'b1;

    always_comb begin
        n_capt    = r_capt;
        n_stored  = r_stored;
        n_buf     = r_buf;
        n_hdr_cnt = r_hdr_cnt;
        n_ftr_cnt = r_ftr_cnt;
        n_cmp_cnt = r_cmp_cnt;
        n_count   = 2'd0;
        n_first   = 8'd0;
        n_second  = 8'd0;
        n_end     = 1'b0;
        n_cmp     = 1'b0;
        if (framing) begin
            if (!r_capt) begin
                if (hdr_hit) begin
                    n_hdr_cnt = r_hdr_cnt + 32'd1;
                    n_capt    = 1'b1;
                    n_stored  = LENGTH_BITS'(2);
                    n_count   = 2'd2;
                    n_first   = r_prev;
                    n_second  = r_in_byte;
                end
            end else if (CW'(r_stored) < CW'(cfg.max_length)) begin
                n_stored = stored_inc;
                n_count  = 2'd1;
                n_second = r_in_byte;
                if (ftr_hit) begin
                    n_end = 1'b1;
                    if (CW'(stored_inc) == CW'(cfg.expected_length)) begin
                        n_cmp     = 1'b1;
                        n_cmp_cnt = r_cmp_cnt + 32'd1;
                    end
                end
            end else if (ftr_hit) begin
                n_end = 1'b1;
            end
            if (n_end) begin
                n_ftr_cnt = r_ftr_cnt + 32'd1;
                n_capt    = 1'b0;
                n_buf     = ~r_buf;
                n_stored  = '0;
            end
        end
        if (CW'(r_offset) + CW'(1) >= CW'(cfg.block_length)) begin
            n_offset = '0;
        end else begin
            n_offset = r_offset + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_prev_vld <= 1'b0;
            r_offset   <= '0;
            r_capt     <= 1'b0;
            r_stored   <= '0;
            r_buf      <= 1'b0;
            r_hdr_cnt  <= '0;
            r_ftr_cnt  <= '0;
            r_cmp_cnt  <= '0;
            r_byte_cnt <= '0;
        end else if (adv) begin
            r_prev     <= r_in_byte;
            r_prev_vld <= 1'b1;
            r_offset   <= n_offset;
            r_capt     <= n_capt;
            r_stored   <= n_stored;
            r_buf      <= n_buf;
            r_hdr_cnt  <= n_hdr_cnt;
            r_ftr_cnt  <= n_ftr_cnt;
            r_cmp_cnt  <= n_cmp_cnt;
            r_byte_cnt <= r_byte_cnt + 64'd1;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_store_count     <= n_count;
            o_first_byte      <= n_first;
            o_second_byte     <= n_second;
            o_buffer_index    <= r_buf;
            o_packet_length   <= 16'(n_stored);
            o_packet_end      <= n_end;
            o_packet_complete <= n_cmp;
            o_header_total    <= n_hdr_cnt;
            o_footer_total    <= n_ftr_cnt;
            o_complete_total  <= n_cmp_cnt;
            o_byte_total      <= r_byte_cnt + 64'd1;
        end
    end

endmodule

`default_nettype wire
